### src/iirt_pkg.sv
// Shared types, widths and helpers for the transposed IIR filter.
`timescale 1ns / 1ps
`default_nettype none

package iirt_pkg;

    localparam int SMP_W   = 16;
    localparam int COEF_W  = 18;
    localparam int PROD_W  = SMP_W + COEF_W;
    localparam int DLY_W   = 40;
    localparam int FRAC    = 14;
    localparam int ACC_W   = DLY_W + 1;
    localparam int YF_W    = ACC_W - FRAC;
    localparam int SUM_W   = DLY_W + 2;
    localparam int SMP_MAX = 32767;
    localparam int SMP_MIN = -32768;

    localparam int NREGS   = 7;
    localparam int IDX_W   = 3;
    localparam int MAXTAPS = 4;

    localparam logic [IDX_W-1:0] REG_B0     = 3'd0;
    localparam int               REG_A_BASE = 3;

    localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd16384;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
    } t_cell_ctl;

    function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [SUM_W-1:0] v);
        logic signed [DLY_W-1:0] r;
        if ((v[SUM_W-1:DLY_W-1] == '0) || (v[SUM_W-1:DLY_W-1] == '1)) begin
            r = v[DLY_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(DLY_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DLY_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/iirt_cell.sv
// One delay cell: holds d(k-1), computes bk*x - ak*y + dk with saturation.
`timescale 1ns / 1ps
`default_nettype none

module iirt_cell
    import iirt_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic signed [COEF_W-1:0] i_coef_b,
    input  wire logic signed [COEF_W-1:0] i_coef_a,
    input  wire logic signed [SMP_W-1:0]  i_x,
    input  wire logic signed [SMP_W-1:0]  i_y,
    input  wire logic signed [DLY_W-1:0]  i_d_next,
    output logic signed [DLY_W-1:0]       o_d
);

    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] w_ay;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [DLY_W-1:0]  r_d;

    assign w_ay  = i_coef_a * i_y;
    assign w_sum = SUM_W'(r_px) - SUM_W'(w_ay) + SUM_W'(i_d_next);

    // feedforward product is taken at the input transfer
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_px <= i_coef_b * i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else if (i_ctl.update) begin
            r_d <= sat_dly(w_sum);
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

### src/iir_filter_transposed.sv
// Top level of the direct form II transposed IIR filter.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_sample_in
//  out     | output    | o_out_valid / i_out_ready  | o_sample_out, o_clipped
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A sample is taken only in idle: the transfer cycle forms b0*x + d0, the
// saturated output and every bk*x; the next cycle updates all delay cells from
// ak*y. The result then moves to the output register; if that is still occupied
// the block holds until it frees and takes no new sample meanwhile.
// Synchronous reset clears delays and control and loads default coefficients;
// cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none

module iir_filter_transposed
    import iirt_pkg::*;
#(
    parameter int TAPS = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic signed [SMP_W-1:0]  i_sample_in,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [SMP_W-1:0]       o_sample_out,
    output logic                          o_clipped,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [IDX_W-1:0]         i_cfg_index,
    input  wire logic signed [COEF_W-1:0] i_cfg_data
);

    logic signed [COEF_W-1:0] r_coef [NREGS];
    t_state                   r_state;
    t_state                   n_state;
    t_cell_ctl                w_ctl;
    logic                     w_in_xfer;
    logic                     w_out_free;
    logic                     w_load_out;

    logic signed [DLY_W-1:0]  w_d [TAPS];
    logic signed [PROD_W-1:0] w_p0;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [YF_W-1:0]   w_yf;
    logic                     w_hi;
    logic                     w_lo;
    logic signed [SMP_W-1:0]  r_y;
    logic                     r_clip;
    logic signed [SMP_W-1:0]  r_sample_out;
    logic                     r_clipped;
    logic                     r_out_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NREGS; i++) begin
                r_coef[i] <= (i == int'(REG_B0)) ? B0_RESET : '0;
            end
        end else if (i_cfg_valid && (int'(i_cfg_index) < NREGS)) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        w_ctl.capture = 1'b0;
        w_ctl.update  = 1'b0;
        w_load_out    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    w_ctl.capture = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                w_ctl.update = 1'b1;
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output sample: floor(acc / 2^14), saturated
    assign w_p0  = r_coef[REG_B0] * i_sample_in;
    assign w_acc = ACC_W'(w_p0) + ACC_W'(w_d[0]);
    assign w_yf  = w_acc[ACC_W-1:FRAC];
    assign w_hi  = (w_yf > $signed(YF_W'(SMP_MAX)));
    assign w_lo  = (w_yf < $signed(YF_W'(SMP_MIN)));

    always_ff @(posedge i_clk) begin
        if (w_ctl.capture) begin
            r_clip <= w_hi || w_lo;
            if (w_hi) begin
                r_y <= $signed(SMP_W'(SMP_MAX));
            end else if (w_lo) begin
                r_y <= $signed(SMP_W'(SMP_MIN));
            end else begin
                r_y <= w_yf[SMP_W-1:0];
            end
        end
    end

    assign w_d[TAPS-1] = '0;

    for (genvar g = 0; g < TAPS - 1; g++) begin : g_cell
        iirt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_coef_b (r_coef[g+1]),
            .i_coef_a (r_coef[REG_A_BASE+g+1]),
            .i_x      (i_sample_in),
            .i_y      (r_y),
            .i_d_next (w_d[g+1]),
            .o_d      (w_d[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_sample_out <= r_y;
            r_clipped    <= r_clip;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

endmodule

`default_nettype wire

### src/iirt_checker.sv
// Port-level checks for the transposed IIR filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module iirt_checker
    import iirt_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_ready,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_ready,
    input wire logic signed [SMP_W-1:0]  o_sample_out,
    input wire logic                     o_clipped
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output valid dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_sample_out) && $stable(o_clipped)))
        else $error("output payload changed while stalled");

    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            ((o_sample_out == 16'sh7fff) || (o_sample_out == 16'sh8000)))
        else $error("clipped result not at a rail");

    a_one_per_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken on consecutive cycles");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not empty after reset");

endmodule

bind iir_filter_transposed iirt_checker u_iirt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out),
    .o_clipped    (o_clipped)
);

`default_nettype wire

### sim/iir_filter_transposed_test.sv
// Self-checking testbench for the transposed IIR filter: directed and random samples vs. predictor.
`timescale 1ns / 1ps

module iir_filter_transposed_test;
    import iirt_pkg::*;

    localparam int     TAPS   = 4;
    localparam longint DLY_HI = 64'sd549755813887;
    localparam longint DLY_LO = -64'sd549755813888;
    localparam int     C_MAX  = 131071;
    localparam int     C_MIN  = -131072;

    typedef enum logic [IDX_W-1:0] {
        CR_B0  = 3'd0,
        CR_B1  = 3'd1,
        CR_B2  = 3'd2,
        CR_B3  = 3'd3,
        CR_A1  = 3'd4,
        CR_A2  = 3'd5,
        CR_A3  = 3'd6,
        CR_BAD = 3'd7
    } t_coef_reg;

    typedef enum int {
        COEF_GENTLE,
        COEF_FULL,
        COEF_EXTREME,
        COEF_UNITY
    } t_coef_kind;

    typedef struct packed {
        logic signed [SMP_W-1:0] smp;
        logic                    clip;
    } t_filter_out;

    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     in_valid  = 1'b0;
    logic signed [SMP_W-1:0]  in_sample = '0;
    logic                     out_ready = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [IDX_W-1:0]         cfg_index = '0;
    logic signed [COEF_W-1:0] cfg_data  = '0;

    logic                     o_in_ready;
    logic                     o_out_valid;
    logic signed [SMP_W-1:0]  o_sample_out;
    logic                     o_clipped;
    logic                     o_cfg_ready;

    logic signed [COEF_W-1:0] coef_q [NREGS];
    logic signed [DLY_W-1:0]  dly_q  [MAXTAPS-1];
    t_filter_out              expected_out_q [$];

    int mismatch_count = 0;
    int rx_hold        = 0;
    bit rx_stalls      = 1'b1;
    bit tx_stalls      = 1'b1;

    iir_filter_transposed #(.TAPS(TAPS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (in_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef(input int lim);
        int v;
        v = int'($urandom_range(0, 2 * lim - 1)) - lim;
        return 18'(v);
    endfunction

    function automatic logic signed [COEF_W-1:0] extreme_coef();
        case ($urandom_range(0, 2))
            0: return 18'(C_MIN);
            1: return 18'(C_MAX);
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [SMP_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 16'($urandom());
        end else if (r < 9) begin
            return 16'($urandom_range(0, 511) - 256);
        end
        return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
    endfunction

    // Golden filter: y = floor((b0*x + d0) >> 14) saturated, then delay update from y.
    function automatic void filter_predict(input logic signed [SMP_W-1:0] smp);
        longint x, acc, y, b, a, nxt, sum;
        t_filter_out r;
        x   = smp;
        b   = coef_q[REG_B0];
        nxt = dly_q[0];
        acc = b * x + nxt;
        y   = acc >>> FRAC;
        r.clip = 1'b0;
        if (y > SMP_MAX) begin
            y = SMP_MAX;
            r.clip = 1'b1;
        end
        if (y < SMP_MIN) begin
            y = SMP_MIN;
            r.clip = 1'b1;
        end
        for (int k = 1; k < TAPS; k++) begin
            b   = coef_q[k];
            a   = coef_q[REG_A_BASE + k];
            nxt = (k < TAPS - 1) ? longint'(dly_q[k]) : 64'sd0;
            sum = b * x - a * y + nxt;
            if (sum > DLY_HI) sum = DLY_HI;
            if (sum < DLY_LO) sum = DLY_LO;
            dly_q[k-1] = sum[DLY_W-1:0];
        end
        r.smp = y[SMP_W-1:0];
        expected_out_q.push_back(r);
    endfunction

    task automatic reset_dut();
        foreach (coef_q[i]) coef_q[i] = '0;
        coef_q[REG_B0] = B0_RESET;
        foreach (dly_q[i]) dly_q[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic send_sample(input logic signed [SMP_W-1:0] x);
        int gap;
        gap = 0;
        if (tx_stalls && $urandom_range(0, 1) != 0) gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid  <= 1'b1;
        in_sample <= x;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        filter_predict(x);
    endtask

    task automatic write_coef(input logic [IDX_W-1:0] idx, input logic signed [COEF_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx < NREGS) coef_q[idx] = val;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Drain: no sample in flight, every result seen, delay update finished.
    task automatic wait_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_out_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_coefs(
        input logic signed [COEF_W-1:0] b0, b1, b2, b3,
        input logic signed [COEF_W-1:0] a1, a2, a3
    );
        wait_idle();
        write_coef(CR_B0, b0);
        write_coef(CR_B1, b1);
        write_coef(CR_B2, b2);
        write_coef(CR_B3, b3);
        write_coef(CR_A1, a1);
        write_coef(CR_A2, a2);
        write_coef(CR_A3, a3);
    endtask

    task automatic test_passthrough();
        send_sample(16'sd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
    endtask

    task automatic test_saturation();
        set_coefs(18'(C_MAX), '0, '0, '0, '0, '0, '0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        set_coefs(18'(C_MIN), '0, '0, '0, '0, '0, '0);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
    endtask

    task automatic test_rounding();
        set_coefs(18'sd8192, '0, '0, '0, '0, '0, '0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd3);
        send_sample(-16'sd3);
    endtask

    task automatic test_feedback_extremes();
        set_coefs(18'(C_MAX), 18'(C_MAX), 18'(C_MIN), 18'(C_MAX),
                  18'(C_MIN), 18'(C_MAX), 18'(C_MIN));
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sd0);
        send_sample(16'sh8000);
        send_sample(16'sd0);
    endtask

    task automatic test_bad_index();
        set_coefs(B0_RESET, 18'sd4096, -18'sd2048, 18'sd1024, 18'sd3000, -18'sd1500, 18'sd700);
        write_coef(CR_BAD, 18'sh1FFFF);
        send_sample(16'sd12345);
        send_sample(-16'sd23456);
    endtask

    // Long receiver hold-off with a back-to-back sender, then a full drain.
    task automatic test_backpressure();
        tx_stalls = 1'b0;
        rx_hold   = 300;
        repeat (24) send_sample(rand_sample());
        wait_idle();
        tx_stalls = 1'b1;
    endtask

    task automatic test_random();
        t_coef_kind kind;
        int         lim_b, lim_a;
        for (int ph = 0; ph < 8; ph++) begin
            kind = t_coef_kind'(ph % 4);
            case (kind)
                COEF_GENTLE: begin
                    lim_b = 8192;
                    lim_a = 2048;
                    set_coefs(rand_coef(lim_b), rand_coef(lim_b), rand_coef(lim_b),
                              rand_coef(lim_b), rand_coef(lim_a), rand_coef(lim_a),
                              rand_coef(lim_a));
                end
                COEF_FULL: begin
                    lim_b = 131072;
                    set_coefs(rand_coef(lim_b), rand_coef(lim_b), rand_coef(lim_b),
                              rand_coef(lim_b), rand_coef(lim_b), rand_coef(lim_b),
                              rand_coef(lim_b));
                end
                COEF_EXTREME: begin
                    set_coefs(extreme_coef(), extreme_coef(), extreme_coef(), extreme_coef(),
                              extreme_coef(), extreme_coef(), extreme_coef());
                end
                default: begin
                    set_coefs(B0_RESET, '0, '0, '0, '0, '0, '0);
                end
            endcase
            tx_stalls = (ph == 2) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
            rx_stalls = (ph == 2) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
            repeat (80) send_sample(rand_sample());
        end
        tx_stalls = 1'b1;
        rx_stalls = 1'b1;
    endtask

    initial begin : receiver
        int gap;
        gap = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                out_ready <= 1'b0;
                rx_hold--;
            end else if (gap > 0) begin
                out_ready <= 1'b0;
                gap--;
            end else begin
                out_ready <= 1'b1;
                if (rx_stalls && $urandom_range(0, 3) == 0) gap = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_output
        t_filter_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_out_q.size() == 0) begin
                $display("%0t: unexpected transfer, sample_out %0d clipped %0b",
                         $time, o_sample_out, o_clipped);
                mismatch_count++;
            end else begin
                want = expected_out_q.pop_front();
                if (o_sample_out !== want.smp) begin
                    $display("%0t: sample_out expected %0d actual %0d",
                             $time, want.smp, o_sample_out);
                    mismatch_count++;
                end
                if (o_clipped !== want.clip) begin
                    $display("%0t: clipped expected %0b actual %0b",
                             $time, want.clip, o_clipped);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        reset_dut();
        test_passthrough();
        test_saturation();
        test_rounding();
        test_feedback_extremes();
        test_bad_index();
        test_backpressure();
        test_random();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
